// ===== hdl/crsf_pkg.sv =====
// crsf frame receiver package: state codes, frame types, register indexes
// and the crc-8 dvb-s2 byte step; no dependencies
package crsf_pkg;

   localparam logic [7:0] TYPE_CHANNELS = 8'h16;
   localparam logic [7:0] TYPE_LINK     = 8'h14;
   localparam logic [7:0] CRC_POLY      = 8'hD5;
   localparam logic [7:0] CRC_MSB       = 8'h80;
   localparam int         MIN_FRAME     = 5;
   localparam int         BYTE_BITS     = 8;

   localparam logic CSR_FRAME_WINDOW = 1'b0;
   localparam logic CSR_OWN_ADDRESS  = 1'b1;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_CRC_RD  = 10'b00_0000_0010,
      S_CRC_ACC = 10'b00_0000_0100,
      S_CHK     = 10'b00_0000_1000,
      S_CH_RD   = 10'b00_0001_0000,
      S_CH_ACC  = 10'b00_0010_0000,
      S_CH_OUT  = 10'b00_0100_0000,
      S_LK_RD   = 10'b00_1000_0000,
      S_LK_ACC  = 10'b01_0000_0000,
      S_LK_OUT  = 10'b10_0000_0000
   } state_type;

   // one byte through the crc, msb first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < BYTE_BITS; i++) begin
         if ((c & CRC_MSB) != 8'h00) c = (c << 1) ^ CRC_POLY;
         else c = c << 1;
      end
      return c;
   endfunction

   function automatic logic signed [8:0] neg9(input logic [7:0] b);
      logic signed [8:0] v;
      v = $signed({b[7], b});
      return -v;
   endfunction

   // bit offset of a channel within the payload
   function automatic logic [7:0] ch_bit(input logic [3:0] ch);
      return 8'(ch) * 8'd11;
   endfunction

   // first store entry of a channel
   function automatic logic [4:0] ch_base(input logic [3:0] ch);
      logic [7:0] bo;
      bo = ch_bit(ch);
      return 5'd3 + bo[7:3];
   endfunction

   // store entries of the link statistics fields, in fetch order
   function automatic logic [3:0] lk_addr(input logic [2:0] step);
      logic [3:0] a;
      case (step)
         3'd0: a = 4'd3;
         3'd1: a = 4'd4;
         3'd2: a = 4'd5;
         3'd3: a = 4'd6;
         3'd4: a = 4'd10;
         3'd5: a = 4'd11;
         3'd6: a = 4'd12;
         default: a = 4'd3;
      endcase
      return a;
   endfunction

endpackage

// ===== hdl/crsf_frame_receiver_top.sv =====
// crsf frame receiver top level: byte framing, crc check and result sequencer
// depends on crsf_pkg
//
// Takes one received byte per word with its arrival time and builds the
// frame in a byte store. A byte is taken while req_stall is low; once a byte
// completes a frame, req_stall stays high while one shared byte path walks
// the store: the crc reads each byte from the type byte up to the byte before
// the crc byte, then a check state follows; a channel frame then takes three
// store reads for each of the sixteen channel words, and link statistics take
// seven store reads before one output word. Output words wait on rsp_stall.
module crsf_frame_receiver_top
   import crsf_pkg::*;
#(
   parameter int FRAME_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [15:0]       csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic [31:0]       req_now_us,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [3:0]        rsp_channel_index,
   output logic [10:0]       rsp_channel_value,
   output logic signed [8:0] rsp_uplink_rssi_a,
   output logic signed [8:0] rsp_uplink_rssi_b,
   output logic [7:0]        rsp_uplink_quality,
   output logic signed [7:0] rsp_uplink_snr,
   output logic signed [8:0] rsp_downlink_rssi,
   output logic [7:0]        rsp_downlink_quality,
   output logic signed [7:0] rsp_downlink_snr,
   output logic              rsp_last
);

   localparam int PW = $clog2(FRAME_BYTES + 1);
   localparam int IW = $clog2(FRAME_BYTES);

   logic [7:0] frame_store [FRAME_BYTES];

   state_type state_ff, state_in;
   logic [15:0] window_ff;
   logic [7:0]  own_addr_ff;
   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0] wstart_ff, wstart_in;
   logic [7:0]  addr0_ff, addr0_in, len_ff, len_in, type_ff, type_in;
   logic [7:0]  crc_byte_ff, crc_byte_in, crc_ff, crc_in;
   logic [PW-1:0] full_ff, full_in, addr_ff, addr_in;
   logic [7:0]  rd_data_ff;
   logic [3:0]  ch_ff, ch_in;
   logic [1:0]  k_ff, k_in;
   logic [2:0]  lk_ff, lk_in;
   logic [23:0] w_ff, w_in;
   logic [55:0] lkb_ff, lkb_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        accept, expired, store_we;
   logic [31:0] delta;
   logic [PW-1:0] pos_eff, full_calc;
   logic [8:0]  len_plus;
   logic [7:0]  rd_byte, crc_next, cbit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign delta     = req_now_us - wstart_ff;
   assign expired   = delta > {16'h0000, window_ff};
   assign pos_eff   = expired ? '0 : pos_ff;
   assign len_plus  = {1'b0, len_ff} + 9'd2;
   assign full_calc = (pos_eff < PW'(3)) ? PW'(MIN_FRAME) :
                      (len_plus > 9'(FRAME_BYTES)) ? PW'(FRAME_BYTES) : PW'(len_plus);
   assign store_we  = accept && (pos_eff < full_calc);
   // entries beyond the store read as zero
   assign rd_byte   = (addr_ff >= PW'(FRAME_BYTES)) ? 8'h00 : rd_data_ff;
   assign crc_next  = crc8_step(crc_ff, rd_byte);
   assign cbit      = ch_bit(ch_ff);

   always_ff @(posedge clock) begin
      if (store_we) frame_store[pos_eff[IW-1:0]] <= req_rx_byte;
      rd_data_ff <= frame_store[addr_ff[IW-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      wstart_in    = wstart_ff;
      addr0_in     = addr0_ff;
      len_in       = len_ff;
      type_in      = type_ff;
      crc_byte_in  = crc_byte_ff;
      crc_in       = crc_ff;
      full_in      = full_ff;
      addr_in      = addr_ff;
      ch_in        = ch_ff;
      k_in         = k_ff;
      lk_in        = lk_ff;
      w_in         = w_ff;
      lkb_in       = lkb_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in = pos_eff;
               if (pos_eff == '0) wstart_in = req_now_us;
               if (store_we) begin
                  if (pos_eff == PW'(0)) addr0_in = req_rx_byte;
                  if (pos_eff == PW'(1)) len_in = req_rx_byte;
                  if (pos_eff == PW'(2)) type_in = req_rx_byte;
                  if (pos_eff + PW'(1) == full_calc) begin
                     pos_in      = '0;
                     full_in     = full_calc;
                     crc_byte_in = req_rx_byte;
                     // the walk starts at the type byte
                     crc_in      = 8'h00;
                     addr_in     = PW'(2);
                     state_in    = S_CRC_RD;
                  end else begin
                     pos_in = pos_eff + PW'(1);
                  end
               end
            end
         end
         S_CRC_RD: state_in = S_CRC_ACC;
         S_CRC_ACC: begin
            crc_in = crc_next;
            if (({1'b0, addr_ff} + (PW+1)'(2)) < {1'b0, full_ff}) begin
               addr_in  = addr_ff + PW'(1);
               state_in = S_CRC_RD;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            ch_in = '0;
            k_in  = '0;
            lk_in = '0;
            if (crc_ff != crc_byte_ff) begin
               state_in = S_IDLE;
            end else if (type_ff == TYPE_CHANNELS && addr0_ff == own_addr_ff) begin
               addr_in  = PW'(ch_base(4'd0));
               state_in = S_CH_RD;
            end else if (type_ff == TYPE_LINK) begin
               addr_in  = PW'(lk_addr(3'd0));
               state_in = S_LK_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CH_RD: state_in = S_CH_ACC;
         S_CH_ACC: begin
            w_in = {rd_byte, w_ff[23:8]};
            if (k_ff == 2'd2) begin
               rsp_valid_in = 1'b1;
               state_in     = S_CH_OUT;
            end else begin
               k_in     = k_ff + 2'd1;
               addr_in  = addr_ff + PW'(1);
               state_in = S_CH_RD;
            end
         end
         S_CH_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (ch_ff == 4'd15) begin
                  state_in = S_IDLE;
               end else begin
                  ch_in    = ch_ff + 4'd1;
                  k_in     = '0;
                  addr_in  = PW'(ch_base(ch_ff + 4'd1));
                  state_in = S_CH_RD;
               end
            end
         end
         S_LK_RD: state_in = S_LK_ACC;
         S_LK_ACC: begin
            lkb_in = {rd_byte, lkb_ff[55:8]};
            if (lk_ff == 3'd6) begin
               rsp_valid_in = 1'b1;
               state_in     = S_LK_OUT;
            end else begin
               lk_in    = lk_ff + 3'd1;
               addr_in  = PW'(lk_addr(lk_ff + 3'd1));
               state_in = S_LK_RD;
            end
         end
         S_LK_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         wstart_ff    <= '0;
         window_ff    <= 16'd1750;
         own_addr_ff  <= 8'd200;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         wstart_ff    <= wstart_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FRAME_WINDOW: window_ff <= csr_write_data;
               CSR_OWN_ADDRESS:  own_addr_ff <= csr_write_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      addr0_ff    <= addr0_in;
      len_ff      <= len_in;
      type_ff     <= type_in;
      crc_byte_ff <= crc_byte_in;
      crc_ff      <= crc_in;
      full_ff     <= full_in;
      addr_ff     <= addr_in;
      ch_ff       <= ch_in;
      k_ff        <= k_in;
      lk_ff       <= lk_in;
      w_ff        <= w_in;
      lkb_ff      <= lkb_in;
   end

   // output word
   always_comb begin
      rsp_valid            = rsp_valid_ff;
      rsp_kind             = (state_ff == S_LK_OUT);
      rsp_channel_index    = 4'd0;
      rsp_channel_value    = 11'd0;
      rsp_uplink_rssi_a    = '0;
      rsp_uplink_rssi_b    = '0;
      rsp_uplink_quality   = 8'd0;
      rsp_uplink_snr       = '0;
      rsp_downlink_rssi    = '0;
      rsp_downlink_quality = 8'd0;
      rsp_downlink_snr     = '0;
      rsp_last             = 1'b0;
      if (state_ff == S_CH_OUT) begin
         rsp_channel_index = ch_ff;
         rsp_channel_value = 11'(w_ff >> cbit[2:0]);
         rsp_last          = (ch_ff == 4'd15);
      end else if (state_ff == S_LK_OUT) begin
         rsp_uplink_rssi_a    = neg9(lkb_ff[7:0]);
         rsp_uplink_rssi_b    = neg9(lkb_ff[15:8]);
         rsp_uplink_quality   = lkb_ff[23:16];
         rsp_uplink_snr       = $signed(lkb_ff[31:24]);
         rsp_downlink_rssi    = neg9(lkb_ff[39:32]);
         rsp_downlink_quality = lkb_ff[47:40];
         rsp_downlink_snr     = $signed(lkb_ff[55:48]);
         rsp_last             = 1'b1;
      end
   end

   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_CH_OUT || state_ff == S_LK_OUT))
      else $error("output word outside an output state");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < PW'(FRAME_BYTES))
      else $error("frame position past the store");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_channel_index)))
      else $error("stalled output word changed");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after last word");
   a_crc_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CRC_ACC) |-> ((addr_ff + PW'(1)) < full_ff))
      else $error("crc walk reached the crc byte");

endmodule
